[rtl/core/mhpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max-heap priority queue package
// Command and status codes shared by the queue and its port checker.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;
  localparam logic [1:0] STATUS_SPARE = 2'd3;

endpackage

[rtl/core/max_heap_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max-heap priority queue
// Fixed-capacity binary max-heap of key/value pairs with insert and
// delete-max, reporting the root pair, the count and a status per item.
// ----------------------------------------------------------------------------
//   channel  direction  fields (low bit first)
//   s_*      in         tdata: entry_key, entry_value; tuser: command
//   m_*      out        tdata: top_key, top_value, count; tuser: is_empty, status
//
// Each heap level costs one read of the entry memory, one or two passes
// through the single key comparator and a write.
// Reset is synchronous and empties the heap; no clearing pass is needed.
// One item is worked at a time; a finished result waits in the output
// register while the next item is taken, and a stalled output holds the
// following result until the register is free.
module max_heap_priority_queue #(
  parameter int HEAP_DEPTH = 64,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // entry_key [15:0], entry_value [31:16]
  input  logic        s_tuser,   // command [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // top_key [15:0], top_value [31:16], count [38:32]
  output logic [2:0]  m_tuser    // is_empty [0], status [2:1]
);

  localparam int AW      = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW      = $clog2(HEAP_DEPTH + 1);
  localparam int ENTRY_W = KEY_BITS + VALUE_BITS;

  typedef enum logic [3:0] {
    IDLE,
    UP_READ,
    UP_CMP,
    DEL_READ,
    DEL_LOAD,
    DOWN_READ,
    DOWN_PICK,
    DOWN_CMP,
    FINISH
  } state_t;

  state_t               state;
  logic [CW-1:0]        count;
  logic [AW-1:0]        pos;
  logic [AW-1:0]        pick_pos;
  logic [ENTRY_W-1:0]   moving;
  logic [ENTRY_W-1:0]   pick;
  logic [ENTRY_W-1:0]   top;
  logic [1:0]           status;

  logic [ENTRY_W-1:0]   mem [HEAP_DEPTH];
  logic [ENTRY_W-1:0]   rd_a;
  logic [ENTRY_W-1:0]   rd_b;
  logic [AW-1:0]        addr_a;
  logic [AW-1:0]        addr_b;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [ENTRY_W-1:0]   wdata;

  logic [KEY_BITS-1:0]  cmp_a;
  logic [KEY_BITS-1:0]  cmp_b;
  logic                 cmp_gt;

  logic [CW:0]          left_idx;
  logic [CW:0]          right_idx;
  logic                 has_left;
  logic                 has_right;
  logic [AW-1:0]        parent;
  logic [AW-1:0]        last;

  assign left_idx  = (CW + 1)'({pos, 1'b1});
  assign right_idx = left_idx + 1'b1;
  assign has_left  = left_idx < {1'b0, count};
  assign has_right = right_idx < {1'b0, count};
  assign parent    = (pos - 1'b1) >> 1;
  assign last      = count[AW-1:0];
  assign cmp_gt    = cmp_a > cmp_b;
  assign s_tready  = (state == IDLE);

  always_comb begin
    addr_a = left_idx[AW-1:0];
    addr_b = right_idx[AW-1:0];
    cmp_a  = moving[KEY_BITS-1:0];
    cmp_b  = rd_a[KEY_BITS-1:0];
    we     = 1'b0;
    waddr  = pos;
    wdata  = moving;
    unique case (state)
      UP_READ: begin
        addr_a = parent;
        if (pos == '0) begin
          we = 1'b1;
        end
      end
      UP_CMP: begin
        we = 1'b1;
        if (cmp_gt) begin
          wdata = rd_a;
        end
      end
      DEL_READ: begin
        addr_a = last;
      end
      DOWN_READ: begin
        we = !has_left;
      end
      DOWN_PICK: begin
        cmp_a = rd_a[KEY_BITS-1:0];
        cmp_b = rd_b[KEY_BITS-1:0];
      end
      DOWN_CMP: begin
        cmp_a = pick[KEY_BITS-1:0];
        cmp_b = moving[KEY_BITS-1:0];
        we    = 1'b1;
        if (cmp_gt) begin
          wdata = pick;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != FINISH) begin
        m_tvalid <= 1'b0;
      end
      if (we && waddr == '0) begin
        top <= wdata;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            moving <= {VALUE_BITS'(s_tdata[31:16]), KEY_BITS'(s_tdata[15:0])};
            if (s_tuser == mhpq_pkg::CMD_INSERT) begin
              if (count < CW'(HEAP_DEPTH)) begin
                status <= mhpq_pkg::STATUS_OK;
                pos    <= count[AW-1:0];
                count  <= count + 1'b1;
                state  <= UP_READ;
              end else begin
                status <= mhpq_pkg::STATUS_FULL;
                state  <= FINISH;
              end
            end else if (count == '0) begin
              status <= mhpq_pkg::STATUS_EMPTY;
              state  <= FINISH;
            end else begin
              status <= mhpq_pkg::STATUS_OK;
              count  <= count - 1'b1;
              state  <= (count == CW'(1)) ? FINISH : DEL_READ;
            end
          end
        end
        UP_READ: begin
          state <= (pos == '0) ? FINISH : UP_CMP;
        end
        UP_CMP: begin
          if (cmp_gt) begin
            pos   <= parent;
            state <= UP_READ;
          end else begin
            state <= FINISH;
          end
        end
        DEL_READ: begin
          state <= DEL_LOAD;
        end
        DEL_LOAD: begin
          moving <= rd_a;
          pos    <= '0;
          state  <= DOWN_READ;
        end
        DOWN_READ: begin
          state <= has_left ? DOWN_PICK : FINISH;
        end
        DOWN_PICK: begin
          if (has_right && !cmp_gt) begin
            pick     <= rd_b;
            pick_pos <= right_idx[AW-1:0];
          end else begin
            pick     <= rd_a;
            pick_pos <= left_idx[AW-1:0];
          end
          state <= DOWN_CMP;
        end
        DOWN_CMP: begin
          if (cmp_gt) begin
            pos   <= pick_pos;
            state <= DOWN_READ;
          end else begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            if (count == '0) begin
              m_tdata[31:0] <= '0;
            end else begin
              m_tdata[31:0] <= {16'(top[ENTRY_W-1:KEY_BITS]), 16'(top[KEY_BITS-1:0])};
            end
            m_tdata[39:32] <= {1'b0, 7'(count)};
            m_tuser        <= {status, count == '0};
            state          <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/mhpq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max-heap priority queue port checker
// Watches the stream ports of the queue and flags illegal results and inputs.
// ----------------------------------------------------------------------------
module mhpq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // A stalled result item must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result item changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[2:1] != mhpq_pkg::STATUS_SPARE)
    else $error("unused status code");

  // An empty heap reports a zero root pair and a zero count.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[38:0] == 39'd0)
    else $error("empty heap with nonzero result fields");

  // The queue works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again while an item is in progress");

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (.*);
